>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Clocked assertion with its own message.
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

`endif

>>> sv/pcns_pkg.sv
// Shared types and constants of the periodic cutoff neighbour search.
// No dependencies.
package pcns_pkg;

    localparam int MAX_ATOMS_DEF = 256;
    localparam int MAX_BONDS_DEF = 4;
    localparam int COORD_W       = 32;
    localparam int BOX_W         = 31;
    localparam int IDX_OUT_W     = 8;
    localparam int LIST_SLOTS    = 4;
    localparam int SQ_W          = 2 * BOX_W;
    localparam int IN_DATA_W     = 104;
    localparam int OUT_DATA_W    = 56;

    typedef enum logic [1:0] {OP_LOAD = 2'd0, OP_QUERY = 2'd1, OP_CLEAR = 2'd2} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_LOADED = 2'd2} status_t;
    typedef enum logic [1:0] {
        CFG_BOX_X = 2'd0, CFG_BOX_Y = 2'd1, CFG_BOX_Z = 2'd2, CFG_CUTOFF = 2'd3
    } cfg_idx_t;
    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_LATCH, S_SWEEP, S_DRAIN, S_RESULT
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pos_t;

    typedef struct packed {
        logic valid;
        logic skip;
    } dist_ctl_t;

    typedef struct packed {
        logic                 valid;
        logic [IDX_OUT_W-1:0] idx;
    } bond_tok_t;

endpackage

>>> sv/pcns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/pcns_dist.sv
// Pair test pipeline: minimum-image gaps, squares, sum, cutoff compare.
// Depends on pcns_pkg.
module pcns_dist #(
    parameter int IDX_W = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pcns_pkg::dist_ctl_t           in_ctl,
    input  logic [IDX_W-1:0]              in_idx,
    input  pcns_pkg::pos_t                q_pos,
    input  pcns_pkg::pos_t                p_pos,
    input  logic [pcns_pkg::BOX_W-1:0]    box_x,
    input  logic [pcns_pkg::BOX_W-1:0]    box_y,
    input  logic [pcns_pkg::BOX_W-1:0]    box_z,
    input  logic [pcns_pkg::BOX_W-1:0]    cutoff,
    input  logic [pcns_pkg::SQ_W-1:0]     cutoff_sq,
    output pcns_pkg::bond_tok_t           bond_tok
);
    import pcns_pkg::*;

    localparam int D_W = COORD_W + 1;
    localparam int W_W = COORD_W + 3;
    localparam int G_W = COORD_W + 2;

    dist_ctl_t            ctl_a_reg, ctl_b_reg, ctl_c_reg, ctl_d_reg;
    logic [IDX_W-1:0]     idx_a_reg, idx_b_reg, idx_c_reg, idx_d_reg;
    logic signed [D_W-1:0] d_reg [3];
    logic [G_W-1:0]       g_reg [3];
    logic [G_W-1:0]       g_next [3];
    logic [SQ_W-1:0]      sq_reg [3];
    logic                 far_c_reg, far_d_reg;
    logic [63:0]          sum_reg;
    logic [BOX_W-1:0]     box [3];
    logic signed [D_W-1:0] d_next [3];
    bond_tok_t            tok_next;
    logic [IDX_OUT_W+IDX_W-1:0] idx_wide;

    assign box[0] = box_x;
    assign box[1] = box_y;
    assign box[2] = box_z;
    assign d_next[0] = D_W'(p_pos.x) - D_W'(q_pos.x);
    assign d_next[1] = D_W'(p_pos.y) - D_W'(q_pos.y);
    assign d_next[2] = D_W'(p_pos.z) - D_W'(q_pos.z);

    // Wrap once by the box length, then take the magnitude.
    always_comb begin
        logic signed [W_W-1:0] dw, d2, l;
        for (int k = 0; k < 3; k++) begin
            dw = W_W'(d_reg[k]);
            l  = W_W'({1'b0, box[k]});
            d2 = dw <<< 1;
            if (d2 < -l) begin
                dw = dw + l;
            end else if (l < d2) begin
                dw = dw - l;
            end
            if (dw < 0) begin
                dw = -dw;
            end
            g_next[k] = dw[G_W-1:0];
        end
    end

    assign idx_wide = (IDX_OUT_W+IDX_W)'(idx_d_reg);
    always_comb begin
        tok_next.valid = ctl_d_reg.valid && !ctl_d_reg.skip && !far_d_reg &&
                         (sum_reg <= 64'(cutoff_sq));
        tok_next.idx   = idx_wide[IDX_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
            bond_tok  <= '0;
        end else begin
            ctl_a_reg <= in_ctl;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
            bond_tok  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_a_reg <= in_idx;
        idx_b_reg <= idx_a_reg;
        idx_c_reg <= idx_b_reg;
        idx_d_reg <= idx_c_reg;
        far_c_reg <= (g_reg[0] > G_W'(cutoff)) || (g_reg[1] > G_W'(cutoff)) ||
                     (g_reg[2] > G_W'(cutoff));
        far_d_reg <= far_c_reg;
        sum_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        for (int k = 0; k < 3; k++) begin
            d_reg[k]  <= d_next[k];
            g_reg[k]  <= g_next[k];
            sq_reg[k] <= SQ_W'(g_reg[k][BOX_W-1:0]) * SQ_W'(g_reg[k][BOX_W-1:0]);
        end
    end
endmodule

>>> sv/pcns_cell.sv
// One neighbour slot: keep the first bond index it sees, pass later ones on.
// Depends on pcns_pkg.
module pcns_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clr,
    input  pcns_pkg::bond_tok_t           tok_in,
    output pcns_pkg::bond_tok_t           tok_out,
    output logic                          full,
    output logic [pcns_pkg::IDX_OUT_W-1:0] value
);
    import pcns_pkg::*;

    logic full_reg;
    logic [IDX_OUT_W-1:0] value_reg;
    bond_tok_t tok_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            full_reg    <= 1'b0;
            tok_out_reg <= '0;
        end else begin
            if (tok_in.valid && !full_reg) begin
                full_reg <= 1'b1;
            end
            tok_out_reg <= (tok_in.valid && full_reg) ? tok_in : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_in.valid && !full_reg) begin
            value_reg <= tok_in.idx;
        end
    end

    assign tok_out = tok_out_reg;
    assign full    = full_reg;
    assign value   = value_reg;
endmodule

>>> sv/periodic_cutoff_neighbor_search.sv
// Top level of the periodic cutoff neighbour search.
// Depends on pcns_pkg, pcns_ram, pcns_dist and pcns_cell.
//
// Load, clear and unused-op requests answer at once with a registered
// result; a query reads the named atom (fetch and latch states), then streams
// every stored atom out of the store RAM at one per cycle through a five-stage
// pair test, and finally drains the pipeline and the neighbour chain. The
// single read port of the atom store bounds the sweep. Bonded indices travel
// as tokens along a chain of MAX_BONDS slot cells, one cell per cycle; each
// cell keeps the first token it meets, so the slots fill in ascending order,
// and a token that falls off the end of the chain raises overflow. New
// requests are taken only while no query is in flight; a waiting result does
// not block the next request once it is being taken.
module periodic_cutoff_neighbor_search #(
    parameter int MAX_ATOMS = pcns_pkg::MAX_ATOMS_DEF,
    parameter int MAX_BONDS = pcns_pkg::MAX_BONDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64], query_index [103:96]
    input  logic [pcns_pkg::IN_DATA_W-1:0]     s_tdata,
    // op [1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // atom_index [7:0], bond_count [15:8], neighbor_0..3 [47:16],
    // overflow [48], zero pad [55:49]
    output logic [pcns_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status [1:0]
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [pcns_pkg::BOX_W-1:0]         cfg_wdata
);
    import pcns_pkg::*;

    localparam int IDX_W   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W   = $clog2(MAX_ATOMS + 1);
    localparam int DRAIN   = MAX_BONDS + 8;
    localparam int DRAIN_W = $clog2(DRAIN + 1);
    localparam int WIDE_W  = 16;

    // Configuration registers.
    logic [BOX_W-1:0] box_x_reg, box_y_reg, box_z_reg, cut_reg;
    logic [SQ_W-1:0]  cut_sq_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   q_addr_reg, q_addr_next;
    logic [IDX_OUT_W-1:0] q_out_reg, q_out_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic [IDX_OUT_W-1:0] bc_reg, bc_next;
    logic               ovf_reg, ovf_next;
    pos_t               q_pos_reg;
    dist_ctl_t          ctl_reg;
    logic [IDX_W-1:0]   ctl_idx_reg;

    logic m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [1:0] m_user_reg, m_user_next;

    logic out_free, in_acc, last_j, q_ok, store_full, chain_clr;
    logic [WIDE_W-1:0] qi_wide;
    logic [IDX_W-1:0] raddr;
    logic ram_we;
    pos_t in_pos, rdata;
    logic [IDX_OUT_W-1:0] qi;
    logic [IDX_OUT_W+CNT_W-1:0] cnt_wide;

    bond_tok_t bond_tok;
    bond_tok_t chain_tok [MAX_BONDS+1];
    logic      cell_full [MAX_BONDS];
    logic [IDX_OUT_W-1:0] cell_val [MAX_BONDS];
    logic [IDX_OUT_W-1:0] nb [LIST_SLOTS];

    assign in_pos.x  = s_tdata[31:0];
    assign in_pos.y  = s_tdata[63:32];
    assign in_pos.z  = s_tdata[95:64];
    assign qi        = s_tdata[103:96];
    assign qi_wide   = WIDE_W'(qi);
    assign q_ok      = qi_wide < WIDE_W'(count_reg);
    assign store_full = count_reg == CNT_W'(MAX_ATOMS);
    assign out_free  = !m_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign last_j    = CNT_W'(j_reg) == count_reg - CNT_W'(1);
    assign cnt_wide  = (IDX_OUT_W+CNT_W)'(count_reg);

    // Configuration writes; square the cutoff once, off the compare path.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg <= '0;
            box_y_reg <= '0;
            box_z_reg <= '0;
            cut_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BOX_X:  box_x_reg <= cfg_wdata;
                CFG_BOX_Y:  box_y_reg <= cfg_wdata;
                CFG_BOX_Z:  box_z_reg <= cfg_wdata;
                CFG_CUTOFF: cut_reg   <= cfg_wdata;
                default:    cut_reg   <= cut_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cut_sq_reg <= SQ_W'(cut_reg) * SQ_W'(cut_reg);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc && s_tuser == OP_QUERY && q_ok) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:  state_next = S_LATCH;
            S_LATCH:  state_next = S_SWEEP;
            S_SWEEP: begin
                if (last_j) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drain_reg == DRAIN_W'(0)) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready  = 1'b0;
        raddr     = q_addr_reg;
        chain_clr = 1'b0;
        case (state_reg)
            S_IDLE:   s_tready  = out_free;
            S_FETCH:  chain_clr = 1'b1;
            S_SWEEP:  raddr     = j_reg;
            default:  raddr     = q_addr_reg;
        endcase
    end

    assign ram_we = in_acc && s_tuser == OP_LOAD && !store_full;

    // Datapath next values.
    always_comb begin
        count_next  = count_reg;
        j_next      = j_reg;
        q_addr_next = q_addr_reg;
        q_out_next  = q_out_reg;
        drain_next  = drain_reg;
        bc_next     = bc_reg;
        ovf_next    = ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (in_acc) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_user_next  = ST_OK;
            case (op_t'(s_tuser))
                OP_LOAD: begin
                    if (store_full) begin
                        m_user_next = ST_FULL;
                    end else begin
                        m_data_next[7:0] = cnt_wide[IDX_OUT_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_QUERY: begin
                    m_data_next[7:0] = qi;
                    if (q_ok) begin
                        m_valid_next = 1'b0;
                        q_addr_next  = qi_wide[IDX_W-1:0];
                        q_out_next   = qi;
                    end else begin
                        m_user_next = ST_NOT_LOADED;
                    end
                end
                OP_CLEAR: count_next = '0;
                default:  m_user_next = ST_OK;
            endcase
        end

        if (state_reg == S_FETCH) begin
            bc_next  = '0;
            ovf_next = 1'b0;
        end else begin
            if (bond_tok.valid && bc_reg != '1) begin
                bc_next = bc_reg + IDX_OUT_W'(1);
            end
            if (chain_tok[MAX_BONDS].valid) begin
                ovf_next = 1'b1;
            end
        end

        if (state_reg == S_LATCH) begin
            j_next = '0;
        end else if (state_reg == S_SWEEP && !last_j) begin
            j_next = j_reg + IDX_W'(1);
        end

        if (state_reg == S_SWEEP) begin
            drain_next = DRAIN_W'(DRAIN);
        end else if (state_reg == S_DRAIN) begin
            drain_next = drain_reg - DRAIN_W'(1);
        end

        if (state_reg == S_RESULT && out_free) begin
            m_valid_next = 1'b1;
            m_user_next  = ST_OK;
            m_data_next  = {7'b0, ovf_reg, nb[3], nb[2], nb[1], nb[0], bc_reg, q_out_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            ctl_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            // Align the pair-test control with the registered RAM read.
            ctl_reg.valid <= state_reg == S_SWEEP;
            ctl_reg.skip  <= j_reg == q_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg       <= j_next;
        q_addr_reg  <= q_addr_next;
        q_out_reg   <= q_out_next;
        drain_reg   <= drain_next;
        bc_reg      <= bc_next;
        ovf_reg     <= ovf_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
        ctl_idx_reg <= j_reg;
        if (state_reg == S_LATCH) begin
            q_pos_reg <= rdata;
        end
    end

    pcns_ram #(
        .WIDTH ($bits(pos_t)),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_pos),
        .raddr (raddr),
        .rdata (rdata)
    );

    pcns_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (ctl_reg),
        .in_idx    (ctl_idx_reg),
        .q_pos     (q_pos_reg),
        .p_pos     (rdata),
        .box_x     (box_x_reg),
        .box_y     (box_y_reg),
        .box_z     (box_z_reg),
        .cutoff    (cut_reg),
        .cutoff_sq (cut_sq_reg),
        .bond_tok  (bond_tok)
    );

    // Neighbour slot chain: bonds enter at cell 0 in ascending index order.
    assign chain_tok[0] = bond_tok;
    for (genvar k = 0; k < MAX_BONDS; k++) begin : g_cell
        pcns_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clr     (chain_clr),
            .tok_in  (chain_tok[k]),
            .tok_out (chain_tok[k+1]),
            .full    (cell_full[k]),
            .value   (cell_val[k])
        );
    end

    // Slots with no bond behind them, or past the chain, read as zero.
    for (genvar k = 0; k < LIST_SLOTS; k++) begin : g_slot
        if (k < MAX_BONDS) begin : g_live
            assign nb[k] = cell_full[k] ? cell_val[k] : '0;
        end else begin : g_none
            assign nb[k] = '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
endmodule

>>> sv/pcns_checker.sv
// Port-level checker for the periodic cutoff neighbour search, bound to the top.
// Depends on pcns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcns_checker #(
    parameter int MAX_BONDS = pcns_pkg::MAX_BONDS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pcns_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);
    import pcns_pkg::*;

    // Hold a stalled result.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Take a request only when the result register can take its answer.
    `ASSERT_CLK_MSG(a_acc_room, aclk, aresetn, s_tvalid && s_tready |-> !m_tvalid || m_tready, "request taken while result stalled")

    // Overflow only above the slot count.
    `ASSERT_CLK_MSG(a_ovf_cnt, aclk, aresetn, m_tvalid && m_tdata[48] |-> m_tdata[15:8] > 8'(MAX_BONDS), "overflow with too few bonds")

    // Failed requests carry no bonds.
    `ASSERT_CLK(a_fail_empty, aclk, aresetn, m_tvalid && m_tuser != ST_OK |-> m_tdata[55:8] == '0)
endmodule

bind periodic_cutoff_neighbor_search pcns_checker #(.MAX_BONDS(MAX_BONDS)) u_pcns_checker (.*);
